// ----- sv/sorted_table_insert_search_delete_defines.svh -----
// Assertion helpers used by the sorted table RTL.
`ifndef SORTED_TABLE_INSERT_SEARCH_DELETE_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_DELETE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/stsd_pkg.sv -----
package stsd_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int OUT_W = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	typedef enum logic {
		PH_IDLE,
		PH_APPLY
	} phase_t;

	// Shift commands broadcast to every cell in the apply cycle.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

// ----- sv/sorted_table_insert_search_delete.sv -----
// Sorted table of up to DEPTH signed 32-bit values held in a row of cells, one
// value per cell, ascending from cell 0. A transaction has an accept cycle and
// an apply cycle: in the accept cycle every cell compares its value with the
// incoming one and latches less-than and equal flags; in the apply cycle the
// row shifts one place (right on insert, left on delete) and the result is
// registered. A new transaction is taken as soon as the apply cycle is done,
// even while the last result still waits; the apply cycle of the next one holds
// until the result register is free. A new value goes ahead of equal entries
// already held; search and delete act on the first equal entry.
`include "sorted_table_insert_search_delete_defines.svh"

module sorted_table_insert_search_delete
	import stsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [4:0] position, [9:5] entry_count
	output logic [1:0]  m_tuser   // [1:0] status
);

	phase_t                  phase_q, phase_d;
	cmd_t                    cmd_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q, count_d;
	logic                    m_tvalid_q;
	logic [15:0]             m_tdata_q;
	status_t                 m_tuser_q;

	logic                    accept;
	logic                    fire;
	logic                    full;
	logic                    found;
	logic [CNT_W-1:0]        pos_raw;
	logic [OUT_W-1:0]        pos_out;
	status_t                 status_d;
	cell_ctl_t               ctl;

	logic signed [VAL_W-1:0] entry_w [DEPTH];
	logic [DEPTH-1:0]        lt_w;
	logic [DEPTH-1:0]        eq_w;
	logic [DEPTH-1:0]        lt_left;
	logic [DEPTH-1:0]        occ;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (phase_q == PH_IDLE);
	assign fire     = (phase_q == PH_APPLY) && (!m_tvalid_q || m_tready);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign found    = |eq_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (accept) phase_d = PH_APPLY;
			end
			PH_APPLY: begin
				if (fire) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(s_tuser);
			key_q <= $signed(s_tdata);
		end
	end

	assign ctl.ins = fire && (cmd_q == CMD_INSERT) && !full;
	assign ctl.del = fire && (cmd_q == CMD_DELETE) && found;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [VAL_W-1:0] left_e;
			logic signed [VAL_W-1:0] right_e;

			if (gi == 0) begin : g_first
				assign lt_left[gi] = 1'b1;
				assign left_e      = key_q;
			end else begin : g_mid
				assign lt_left[gi] = lt_w[gi-1];
				assign left_e      = entry_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_e = entry_w[gi];
			end else begin : g_inner
				assign right_e = entry_w[gi+1];
			end

			assign occ[gi] = (CNT_W'(gi) < count_q);

			stsd_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.sample      (accept),
				.occ         (occ[gi]),
				.cmp_key     ($signed(s_tdata)),
				.ins_key     (key_q),
				.left_entry  (left_e),
				.right_entry (right_e),
				.left_lt     (lt_left[gi]),
				.ctl         (ctl),
				.entry       (entry_w[gi]),
				.lt          (lt_w[gi]),
				.eq          (eq_w[gi])
			);
		end
	endgenerate

	// Less-than flags form a prefix; the boundary cell is where it ends.
	always_comb begin
		pos_raw = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lt_left[i] && !lt_w[i]) pos_raw = pos_raw | CNT_W'(i + 1);
		end
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_DONE;
		pos_out  = '0;
		case (cmd_q)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					pos_out = OUT_W'(pos_raw);
				end
			end
			CMD_SEARCH: begin
				if (found) begin
					pos_out = OUT_W'(pos_raw);
				end else begin
					status_d = ST_MISSING;
				end
			end
			CMD_DELETE: begin
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_MISSING;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tuser_q <= status_d;
			m_tdata_q <= {6'd0, OUT_W'(count_d), pos_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`STSD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`STSD_ASSERT_NEXT(a_accept_apply, accept, phase_q == PH_APPLY, "no apply after accept")
	`STSD_ASSERT_NEXT(a_count_hold, !fire, count_q == $past(count_q), "count moved outside apply")
	`STSD_ASSERT_NEXT(a_insert_grow, ctl.ins, count_q == $past(count_q) + CNT_W'(1),
		"insert did not grow table")
	`STSD_ASSERT_NOW(a_delete_hit, ctl.del, count_q != '0, "delete hit on empty table")

endmodule

// ----- sv/stsd_cell.sv -----
module stsd_cell
	import stsd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample,
	input  logic                    occ,
	input  logic signed [VAL_W-1:0] cmp_key,
	input  logic signed [VAL_W-1:0] ins_key,
	input  logic signed [VAL_W-1:0] left_entry,
	input  logic signed [VAL_W-1:0] right_entry,
	input  logic                    left_lt,
	input  cell_ctl_t               ctl,
	output logic signed [VAL_W-1:0] entry,
	output logic                    lt,
	output logic                    eq
);

	logic signed [VAL_W-1:0] entry_q;
	logic                    lt_q;
	logic                    eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (sample) begin
			lt_q <= occ & (entry_q < cmp_key);
			eq_q <= occ & (entry_q == cmp_key);
		end
	end

	// Cells at or past the boundary move: right on insert, left on delete.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			entry_q <= left_lt ? ins_key : left_entry;
		end else if (ctl.del && !lt_q) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule
